### src/undirected_euler_circuit_defines.svh
// Assertion macros for the checker file of the Euler circuit block
`ifndef UNDIRECTED_EULER_CIRCUIT_DEFINES_SVH
`define UNDIRECTED_EULER_CIRCUIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define EUC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define EUC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/euc_pkg.sv
// Types, constants and codes of the Euler circuit block
package euc_pkg;

  localparam int VERTEX_W       = 3;   // width of vertex fields
  localparam int FIELD_VERTICES = 8;   // reach of a vertex field
  localparam int MAX_VERT_DEF   = 8;   // default number of matrix rows
  localparam int CMD_W          = 2;
  localparam int CFG_W          = 4;
  localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;
  localparam int STORE_DEPTH    = 30;  // walk stack and circuit buffer depth
  localparam int DEPTH_W        = 5;   // holds 0..STORE_DEPTH

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // Matrix update operations
  localparam logic [1:0] ADJ_NOP   = 2'd0;
  localparam logic [1:0] ADJ_SET   = 2'd1;
  localparam logic [1:0] ADJ_DEL   = 2'd2;
  localparam logic [1:0] ADJ_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]          kind;
    logic [VERTEX_W-1:0] a;
    logic [VERTEX_W-1:0] b;
  } adj_op_t;

endpackage

### src/euc_adj.sv
// Adjacency bit matrix with one row read port and symmetric edge updates
module euc_adj import euc_pkg::*; #(
  parameter int NV = MAX_VERT_DEF,
  parameter int VW = $clog2(NV)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  adj_op_t       op,
  input  logic [VW-1:0] rd_idx,
  output logic [NV-1:0] rd_row
);

  logic [NV-1:0] rows_r [NV];
  logic [VW-1:0] ia;
  logic [VW-1:0] ib;

  assign ia     = op.a[VW-1:0];
  assign ib     = op.b[VW-1:0];
  assign rd_row = rows_r[rd_idx];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NV; i++) rows_r[i] <= '0;
    end else begin
      unique case (op.kind)
        ADJ_SET: begin
          rows_r[ia][ib] <= 1'b1;
          rows_r[ib][ia] <= 1'b1;
        end
        ADJ_DEL: begin
          rows_r[ia][ib] <= 1'b0;
          rows_r[ib][ia] <= 1'b0;
        end
        ADJ_CLEAR: begin
          for (int i = 0; i < NV; i++) rows_r[i] <= '0;
        end
        default: ;
      endcase
    end
  end

endmodule

### src/euc_topbit.sv
// Neighbour picker: index of the highest set bit of a row
module euc_topbit import euc_pkg::*; #(
  parameter int NV = MAX_VERT_DEF,
  parameter int VW = $clog2(NV)
) (
  input  logic [NV-1:0] row,
  output logic [VW-1:0] idx
);

  always_comb begin
    idx = '0;
    for (int i = 0; i < NV; i++) begin
      if (row[i]) idx = VW'(i);
    end
  end

endmodule

### src/euc_store.sv
// Small register file: one write port, one unregistered read port
module euc_store import euc_pkg::*; #(
  parameter int DEPTH = STORE_DEPTH,
  parameter int W     = VERTEX_W,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [W-1:0]  wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [W-1:0]  rd_data
);

  logic [W-1:0] mem_r [DEPTH];

  assign rd_data = mem_r[rd_addr];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_addr] <= wr_data;
  end

endmodule

### src/undirected_euler_circuit.sv
// Euler circuit of an undirected graph: edge loading, Hierholzer walk, circuit output
// Add edge, clear and unused commands: no result.
// Run: start, then 2*E+1 walk steps for E reachable edges (the matrix row read and
// neighbour pick bound each step), then one result per cycle while out_ready holds;
// no new item is taken until the last result is loaded.
// Reset (rst_n low, synchronous): matrix empty, vertex_count 8, sequencer idle.
module undirected_euler_circuit import euc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    in_cmd,
  input  logic [VERTEX_W-1:0] in_vertex_a,
  input  logic [VERTEX_W-1:0] in_vertex_b,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [VERTEX_W-1:0] out_vertex,
  output logic                out_status,
  output logic                out_last,
  input  logic                cfg_wr_en,
  input  logic [CFG_W-1:0]    cfg_wr_data
);

  // Matrix rows actually needed: vertex fields reach 8 at most
  localparam int NV = (MAX_VERTICES < FIELD_VERTICES) ? MAX_VERTICES : FIELD_VERTICES;
  localparam int VW = $clog2(NV);
  localparam int CW = $clog2(NV + 1);

  // Sequencer
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [CFG_W-1:0]   vcount_r;
  logic [VW-1:0]      cur_r, cur_nxt;
  logic [DEPTH_W-1:0] depth_r, depth_nxt;   // walk stack fill
  logic [DEPTH_W-1:0] len_r, len_nxt;       // circuit buffer fill
  logic [DEPTH_W-1:0] idx_r, idx_nxt;       // emit position, counts down
  logic [VW-1:0]      first_r, first_nxt;   // first vertex appended to the circuit
  logic [VW-1:0]      lastv_r, lastv_nxt;   // latest vertex appended
  logic               fail_r, fail_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VERTEX_W-1:0] out_vertex_r, out_vertex_nxt;
  logic                out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  // Effective vertex count and its row mask
  logic [CW-1:0] n_eff;
  logic [NV-1:0] mask;

  always_comb begin
    if (vcount_r == '0) n_eff = CW'(1);
    else if (32'(vcount_r) > NV) n_eff = CW'(NV);
    else n_eff = CW'(vcount_r);
    for (int i = 0; i < NV; i++) mask[i] = (i < 32'(n_eff));
  end

  // Matrix, neighbour picker, walk stack and circuit buffer
  adj_op_t       adj_op;
  logic [NV-1:0] row_raw, row_m;
  logic [VW-1:0] nxt_v;

  logic               stk_we;
  logic [DEPTH_W-1:0] stk_waddr;
  logic [VW-1:0]      stk_wdata, stk_rdata;
  logic               buf_we;
  logic [VW-1:0]      buf_rdata;

  euc_adj #(.NV(NV), .VW(VW)) u_adj (
    .clk    (clk),
    .rst_n  (rst_n),
    .op     (adj_op),
    .rd_idx (cur_r),
    .rd_row (row_raw)
  );

  assign row_m = row_raw & mask;

  euc_topbit #(.NV(NV), .VW(VW)) u_topbit (
    .row (row_m),
    .idx (nxt_v)
  );

  euc_store #(.DEPTH(STORE_DEPTH), .W(VW), .AW(DEPTH_W)) u_stack (
    .clk     (clk),
    .wr_en   (stk_we),
    .wr_addr (stk_waddr),
    .wr_data (stk_wdata),
    .rd_addr (depth_r - DEPTH_W'(1)),
    .rd_data (stk_rdata)
  );

  euc_store #(.DEPTH(STORE_DEPTH), .W(VW), .AW(DEPTH_W)) u_circ (
    .clk     (clk),
    .wr_en   (buf_we),
    .wr_addr (len_r),
    .wr_data (cur_r),
    .rd_addr (idx_r - DEPTH_W'(1)),
    .rd_data (buf_rdata)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_vertex = out_vertex_r;
  assign out_status = out_status_r;
  assign out_last   = out_last_r;

  logic accept;
  logic edge_ok;
  logic step_fwd;
  logic out_free;
  logic [VW-1:0] first_v;

  assign accept   = in_valid & in_ready;
  assign edge_ok  = (in_vertex_a != in_vertex_b) &&
                    (4'(in_vertex_a) < 4'(n_eff)) && (4'(in_vertex_b) < 4'(n_eff));
  // Unused edge out of the current vertex and room to push
  assign step_fwd = (row_m != '0) && (depth_r < DEPTH_W'(STORE_DEPTH));
  assign out_free = !out_valid_r || out_ready;
  assign first_v  = (len_r == '0) ? cur_r : first_r;

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    depth_nxt      = depth_r;
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    first_nxt      = first_r;
    lastv_nxt      = lastv_r;
    fail_nxt       = fail_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_vertex_nxt = out_vertex_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    adj_op         = '{kind: ADJ_NOP, a: '0, b: '0};
    stk_we         = 1'b0;
    stk_waddr      = depth_r;
    stk_wdata      = cur_r;
    buf_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_ADD: begin
              if (edge_ok) adj_op = '{kind: ADJ_SET, a: in_vertex_a, b: in_vertex_b};
            end
            CMD_RUN: begin
              // stack bottom holds vertex 0; the walk's first push, if any, is vertex 0 again
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = '0;
              depth_nxt = DEPTH_W'(1);
              len_nxt   = '0;
              cur_nxt   = '0;
              state_nxt = S_WALK;
            end
            CMD_CLEAR: adj_op = '{kind: ADJ_CLEAR, a: '0, b: '0};
            default: ;
          endcase
        end
      end

      S_WALK: begin
        if (step_fwd) begin
          // push, consume the edge, move on
          stk_we    = 1'b1;
          depth_nxt = depth_r + DEPTH_W'(1);
          adj_op    = '{kind: ADJ_DEL, a: VERTEX_W'(cur_r), b: VERTEX_W'(nxt_v)};
          cur_nxt   = nxt_v;
        end else begin
          // stuck: append to circuit and back off
          if (len_r < DEPTH_W'(STORE_DEPTH)) begin
            buf_we    = 1'b1;
            len_nxt   = len_r + DEPTH_W'(1);
            first_nxt = first_v;
            lastv_nxt = cur_r;
          end
          depth_nxt = depth_r - DEPTH_W'(1);
          cur_nxt   = stk_rdata;
          if (depth_r == DEPTH_W'(1)) begin
            fail_nxt  = (len_nxt == '0) || (first_nxt != lastv_nxt);
            idx_nxt   = len_nxt;
            state_nxt = S_EMIT;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (fail_r) begin
            out_vertex_nxt = '0;
            out_status_nxt = 1'b1;
            out_last_nxt   = 1'b1;
            state_nxt      = S_IDLE;
          end else begin
            // circuit buffer read backwards so output starts at vertex 0
            out_vertex_nxt = VERTEX_W'(buf_rdata);
            out_status_nxt = 1'b0;
            out_last_nxt   = (idx_r == DEPTH_W'(1));
            idx_nxt        = idx_r - DEPTH_W'(1);
            if (idx_r == DEPTH_W'(1)) state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= CFG_RESET;
      depth_r     <= '0;
      len_r       <= '0;
      idx_r       <= '0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) vcount_r <= cfg_wr_data;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    cur_r        <= cur_nxt;
    first_r      <= first_nxt;
    lastv_r      <= lastv_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

### src/euc_checker.sv
// Port-level checks of the Euler circuit block, bound to the top level
`include "undirected_euler_circuit_defines.svh"

module euc_checker import euc_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [CMD_W-1:0]    in_cmd,
  input logic                out_valid,
  input logic                out_ready,
  input logic [VERTEX_W-1:0] out_vertex,
  input logic                out_status,
  input logic                out_last
);

  // stalled result holds
  `EUC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
    out_valid && $stable(out_vertex) && $stable(out_status) && $stable(out_last),
    "stalled result changed")

  // a no-circuit result stands alone
  `EUC_ASSERT_IMP(a_fail_alone, clk, rst_n, out_valid && out_status,
    out_last && (out_vertex == '0), "no-circuit result not final or not vertex 0")

  // a run keeps the block busy
  `EUC_ASSERT_NXT(a_run_busy, clk, rst_n, in_valid && in_ready && (in_cmd == CMD_RUN),
    !in_ready, "ready straight after a run")

  // more results to come means no new item
  `EUC_ASSERT_IMP(a_emit_busy, clk, rst_n, out_valid && !out_last,
    !in_ready, "ready while a circuit is still being emitted")

endmodule

bind undirected_euler_circuit euc_checker u_euc_checker (.*);

### sim/testbench.sv
// Self-checking testbench for the undirected Euler circuit block
`timescale 1ns / 100ps

module testbench;
  import euc_pkg::*;

  localparam int NUM_VERTICES   = MAX_VERT_DEF;
  localparam int CLK_HALF       = 10;    // 20 ns period
  localparam int RESET_CYCLES   = 7;
  localparam int IDLE_SETTLE    = 4;     // lets add, clear and unused items finish
  localparam int END_SETTLE     = 16;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
  localparam int RANDOM_ITEMS   = 20;
  localparam int STALL_PHASE    = 97;    // cycles per receiver stall pattern

  // cmd 3 has no meaning in the block; it must be swallowed silently
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef logic [VERTEX_W-1:0]       vertex_t;
  typedef logic [FIELD_VERTICES-1:0] row_t;

  typedef struct packed {
    vertex_t vertex;
    logic    status;
    logic    last;
  } circuit_step_t;

  typedef enum int {RX_READY, RX_RANDOM, RX_TOGGLE, RX_HOLD} stall_mode_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  logic [CMD_W-1:0] in_cmd;
  vertex_t          in_vertex_a;
  vertex_t          in_vertex_b;
  logic             out_valid;
  logic             out_ready;
  vertex_t          out_vertex;
  logic             out_status;
  logic             out_last;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;

  undirected_euler_circuit #(
    .MAX_VERTICES(NUM_VERTICES)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_cmd     (in_cmd),
    .in_vertex_a(in_vertex_a),
    .in_vertex_b(in_vertex_b),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_vertex (out_vertex),
    .out_status (out_status),
    .out_last   (out_last),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: our own copy of the edge matrix and the vertex count
  // ---------------------------------------------------------------------------
  row_t             graph_rows [FIELD_VERTICES];
  logic [CFG_W-1:0] vertex_count;
  circuit_step_t    expected_circuit [$];   // vertices still owed by the block

  int unsigned error_count;
  int unsigned work_items;   // items that added an edge, cleared the graph or started a walk
  int unsigned burst_left;   // items left in the sender's current burst

  // Count of 0 behaves as 1; anything past the matrix or the field reach saturates
  function automatic int unsigned active_vertices();
    int unsigned n;
    n = vertex_count;
    if (n < 1) n = 1;
    if (n > NUM_VERTICES) n = NUM_VERTICES;
    if (n > FIELD_VERTICES) n = FIELD_VERTICES;
    return n;
  endfunction

  // Hierholzer walk from vertex 0, highest neighbour first. Walked edges are
  // removed from graph_rows; the circuit (or the no-circuit marker) is queued.
  task automatic trace_circuit();
    int unsigned n;
    int unsigned cur;
    int unsigned nxt;
    int unsigned depth;
    int unsigned length;
    int          i;
    row_t        mask;
    row_t        row;
    int unsigned degree [FIELD_VERTICES];
    vertex_t     path_stack [STORE_DEPTH];
    vertex_t     circuit [STORE_DEPTH];
    circuit_step_t step;
    n = active_vertices();
    mask = '0;
    for (i = 0; i < n; i++) begin
      mask[i] = 1'b1;
    end
    // degrees only see edges inside the active range
    for (i = 0; i < n; i++) begin
      degree[i] = $countones(graph_rows[i] & mask);
    end
    depth = 0;
    length = 0;
    cur = 0;
    path_stack[0] = '0;
    depth = 1;
    while (depth > 0) begin
      row = graph_rows[cur] & mask;
      if (degree[cur] != 0 && row != '0 && depth < STORE_DEPTH) begin
        nxt = 0;
        for (i = 0; i < FIELD_VERTICES; i++) begin
          if (row[i]) nxt = i;
        end
        path_stack[depth] = vertex_t'(cur);
        depth++;
        degree[cur]--;
        if (degree[nxt] != 0) degree[nxt]--;
        graph_rows[cur][nxt] = 1'b0;
        graph_rows[nxt][cur] = 1'b0;
        cur = nxt;
      end else begin
        // stuck: record the vertex and back off
        if (length < STORE_DEPTH) begin
          circuit[length] = vertex_t'(cur);
          length++;
        end
        depth--;
        cur = path_stack[depth];
      end
    end
    if (length == 0 || circuit[0] != circuit[length - 1]) begin
      step.vertex = '0;
      step.status = 1'b1;
      step.last   = 1'b1;
      expected_circuit.insert(expected_circuit.size(), step);
    end else begin
      // buffer was filled back to front, so it comes out reversed
      for (i = length; i > 0; i--) begin
        step.vertex = circuit[i - 1];
        step.status = 1'b0;
        step.last   = (i == 1);
        expected_circuit.insert(expected_circuit.size(), step);
      end
    end
  endtask

  // Apply one accepted item; changed is low when the block just drops it
  task automatic update_graph(input logic [CMD_W-1:0] cmd, input vertex_t a, input vertex_t b,
                              output bit changed);
    int unsigned n;
    int          i;
    n = active_vertices();
    changed = 1'b1;
    case (cmd)
      CMD_ADD: begin
        if (a != b && a < n && b < n && !graph_rows[a][b]) begin
          graph_rows[a][b] = 1'b1;
          graph_rows[b][a] = 1'b1;
        end else begin
          changed = 1'b0;
        end
      end
      CMD_RUN: trace_circuit();
      CMD_CLEAR: begin
        for (i = 0; i < FIELD_VERTICES; i++) begin
          graph_rows[i] = '0;
        end
      end
      default: changed = 1'b0;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin : clock_gen
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Sender. Entered and left at a falling edge. Items go out in bursts; valid
  // stays up across a burst and only drops at its end or before a pause.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [CMD_W-1:0] cmd, input vertex_t a, input vertex_t b);
    bit changed;
    if (burst_left == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      // now and then a long burst, so some stretches have no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 5);
    end
    in_cmd      = cmd;
    in_vertex_a = a;
    in_vertex_b = b;
    in_valid    = 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    update_graph(cmd, a, b, changed);
    if (changed) work_items++;
    burst_left--;
    @(negedge clk);
    if (burst_left == 0) in_valid = 1'b0;
  endtask

  // Hold off until the block owes nothing, then let any add or clear finish
  task automatic wait_drained();
    in_valid = 1'b0;
    burst_left = 0;
    while (expected_circuit.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(negedge clk);
  endtask

  task automatic write_vertex_count(input logic [CFG_W-1:0] value);
    wait_drained();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en    = 1'b0;
    vertex_count = value;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: rotates through its own stall patterns, independent of the sender
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned tick;
    int unsigned hold;
    stall_mode_t mode;
    out_ready = 1'b0;
    tick = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      mode = stall_mode_t'((tick / STALL_PHASE) % 4);
      case (mode)
        RX_READY:  out_ready = 1'b1;
        RX_RANDOM: out_ready = ($urandom_range(0, 3) != 0);
        RX_TOGGLE: out_ready = ~out_ready;
        default: begin
          if (hold == 0) begin
            out_ready = 1'($urandom_range(0, 1));
            hold = $urandom_range(1, 6);
          end
          hold--;
        end
      endcase
      tick++;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    circuit_step_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (expected_circuit.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected: expected nothing, %s %0d %0d %0d",
                 $time, "got vertex, status, last", out_vertex, out_status, out_last);
      end else begin
        want = expected_circuit.pop_front();
        if (out_vertex !== want.vertex) begin
          error_count++;
          $display("%0t: vertex mismatch: expected %0d, got %0d", $time, want.vertex, out_vertex);
        end
        if (out_status !== want.status) begin
          error_count++;
          $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, out_status);
        end
        if (out_last !== want.last) begin
          error_count++;
          $display("%0t: last mismatch: expected %0d, got %0d", $time, want.last, out_last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: the limit is far beyond the quiet stretch of a long walk or of any
  // correct stall
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("undirected_euler_circuit verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Hand-picked graphs at the reset count of 8
  task automatic test_directed_cases();
    send_item(CMD_RUN, 0, 0);      // empty graph: lone vertex 0
    send_item(CMD_ADD, 0, 1);
    send_item(CMD_ADD, 1, 2);
    send_item(CMD_ADD, 2, 0);
    send_item(CMD_RUN, 7, 7);      // endpoint fields mean nothing on a run
    send_item(CMD_ADD, 3, 3);      // self-loop, dropped
    send_item(CMD_ADD, 7, 0);
    send_item(CMD_ADD, 0, 7);      // already there
    send_item(CMD_ADD, 7, 6);
    send_item(CMD_ADD, 6, 0);
    send_item(CMD_UNUSED, 7, 7);   // unused command, swallowed
    send_item(CMD_RUN, 0, 0);
    send_item(CMD_ADD, 0, 1);      // single edge: walk ends away from 0
    send_item(CMD_RUN, 0, 0);
    send_item(CMD_ADD, 5, 4);      // triangle that vertex 0 cannot reach
    send_item(CMD_ADD, 4, 3);
    send_item(CMD_ADD, 3, 5);
    send_item(CMD_ADD, 0, 2);
    send_item(CMD_ADD, 2, 1);
    send_item(CMD_ADD, 1, 0);
    send_item(CMD_RUN, 0, 0);
    send_item(CMD_RUN, 0, 0);      // only the far triangle is left
    send_item(CMD_CLEAR, 7, 7);
    send_item(CMD_RUN, 0, 0);
  endtask

  // Count register at its extremes; edges left beyond a lowered count
  task automatic test_vertex_count_limits();
    write_vertex_count(4'd0);      // behaves as one vertex
    send_item(CMD_ADD, 0, 1);      // out of range, dropped
    send_item(CMD_RUN, 0, 0);
    write_vertex_count(4'd15);     // saturates to 8
    send_item(CMD_ADD, 0, 7);
    send_item(CMD_ADD, 7, 3);
    send_item(CMD_ADD, 3, 0);
    write_vertex_count(4'd3);      // those edges are now invisible
    send_item(CMD_RUN, 0, 0);
    write_vertex_count(4'd8);      // and back again, still intact
    send_item(CMD_RUN, 0, 0);
    write_vertex_count(4'd1);
    send_item(CMD_RUN, 0, 0);
    write_vertex_count(4'd2);
    send_item(CMD_ADD, 1, 0);
    send_item(CMD_RUN, 0, 0);
  endtask

  // Complete graphs: K7 gives the longest circuit, K8 the deepest stack
  task automatic test_dense_graphs();
    logic [2*VERTEX_W-1:0] pairs [$];
    logic [2*VERTEX_W-1:0] swap_pair;
    int size;
    int i;
    int j;
    for (size = 7; size <= 8; size++) begin
      write_vertex_count(CFG_W'(size));
      send_item(CMD_CLEAR, 0, 0);
      pairs.delete();
      for (i = 0; i < size; i++) begin
        for (j = i + 1; j < size; j++) begin
          pairs.insert(pairs.size(), {vertex_t'(i), vertex_t'(j)});
        end
      end
      for (i = pairs.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        swap_pair = pairs[i];
        pairs[i] = pairs[j];
        pairs[j] = swap_pair;
      end
      foreach (pairs[i]) begin
        if ($urandom_range(0, 1)) send_item(CMD_ADD, pairs[i][5:3], pairs[i][2:0]);
        else send_item(CMD_ADD, pairs[i][2:0], pairs[i][5:3]);
      end
      send_item(CMD_RUN, 0, 0);
    end
  endtask

  // Mostly graphs built from closed cycles, with noise and broken cycles mixed in
  task automatic test_random_graphs();
    int unsigned target;
    int unsigned n;
    int unsigned graph_no;
    int          len;
    int          style;
    int          cycles;
    int          noise_at;
    int          c;
    int          i;
    int          j;
    vertex_t     order [FIELD_VERTICES];
    vertex_t     tv;
    target = work_items + RANDOM_ITEMS;
    graph_no = 0;
    while (work_items < target) begin
      if ($urandom_range(0, 3) == 0) begin
        // mostly mid counts where walks get interesting, sometimes anything
        if ($urandom_range(0, 2) == 0) write_vertex_count(CFG_W'($urandom_range(0, 15)));
        else write_vertex_count(CFG_W'($urandom_range(4, 8)));
      end else if (graph_no % 5 == 4) begin
        wait_drained();            // sender holds back until the circuit is all out
      end
      if ($urandom_range(0, 4) == 0) begin
        send_item(CMD_CLEAR, vertex_t'($urandom_range(0, 7)), vertex_t'($urandom_range(0, 7)));
      end
      n = active_vertices();
      style = $urandom_range(0, 9);
      if (style == 7) begin
        // raw edges over the whole field range
        repeat ($urandom_range(1, 5)) begin
          send_item(CMD_ADD, vertex_t'($urandom_range(0, 7)), vertex_t'($urandom_range(0, 7)));
        end
      end else if (n < 3) begin
        send_item(CMD_ADD, vertex_t'($urandom_range(0, 1)), vertex_t'($urandom_range(0, 1)));
      end else begin
        cycles = $urandom_range(1, 3);
        for (c = 0; c < cycles; c++) begin
          for (i = 0; i < n; i++) begin
            order[i] = vertex_t'(i);
          end
          for (i = n - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tv = order[i];
            order[i] = order[j];
            order[j] = tv;
          end
          // usually pull vertex 0 in, so the walk reaches the cycle
          if ($urandom_range(0, 9) < 7) begin
            for (i = 1; i < n; i++) begin
              if (order[i] == '0) begin
                order[i] = order[0];
                order[0] = '0;
              end
            end
          end
          len = $urandom_range(3, n);
          noise_at = $urandom_range(0, len - 1);
          for (i = 0; i < len; i++) begin
            if (style == 8 && i == noise_at) begin
              tv = vertex_t'($urandom_range(0, 7));
              send_item(($urandom_range(0, 1) != 0) ? CMD_UNUSED : CMD_ADD, tv, tv);
            end
            // broken variant leaves the first cycle open
            if (!(style == 9 && c == 0 && i == len - 1)) begin
              if ($urandom_range(0, 1)) send_item(CMD_ADD, order[i], order[(i + 1) % len]);
              else send_item(CMD_ADD, order[(i + 1) % len], order[i]);
            end
          end
        end
      end
      send_item(CMD_RUN, vertex_t'($urandom_range(0, 7)), vertex_t'($urandom_range(0, 7)));
      graph_no++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int i;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_cmd      = CMD_ADD;
    in_vertex_a = '0;
    in_vertex_b = '0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    error_count = 0;
    work_items  = 0;
    burst_left  = 0;
    for (i = 0; i < FIELD_VERTICES; i++) begin
      graph_rows[i] = '0;
    end
    vertex_count = CFG_RESET;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_vertex_count_limits();
    test_dense_graphs();
    test_random_graphs();

    wait_drained();
    repeat (END_SETTLE) @(posedge clk);
    if (error_count == 0 && expected_circuit.size() == 0) begin
      $display("undirected_euler_circuit verification clean");
    end else begin
      $display("undirected_euler_circuit verification failed");
    end
    $finish;
  end

endmodule
